// File: src/shca_pkg.sv
package shca_pkg;

  localparam int POS_W      = 24;
  localparam int IDX_W      = 12;
  localparam int BND_W      = 25;
  localparam int COORD_W    = 8;
  localparam int NUM_AXES   = 3;
  localparam int NUM_OFFS   = 27;
  localparam int HOME_OFF   = 13;
  localparam int DIV_BITS   = 3;
  localparam int DIV_STAGES = POS_W / DIV_BITS;
  localparam int ENTRIES    = 8;

  localparam logic [1:0] REG_CELL_SIZE  = 2'd0;
  localparam logic [1:0] REG_LOW_BOUND  = 2'd1;
  localparam logic [1:0] REG_HIGH_BOUND = 2'd2;

  localparam logic [POS_W-1:0] CELL_SIZE_RST  = 24'd256;
  localparam logic [BND_W-1:0] LOW_BOUND_RST  = 25'd0;
  localparam logic [BND_W-1:0] HIGH_BOUND_RST = 25'd2560000;

  // Divider pipeline item: bnd bit d set when offset d-1 stays inside the bounds
  typedef struct packed {
    logic                                 v;
    logic [IDX_W-1:0]                     idx;
    logic [NUM_AXES-1:0][POS_W-1:0]       pos;
    logic [POS_W-1:0]                     rad;
    logic [NUM_AXES-1:0][POS_W-1:0]       rem;
    logic [NUM_AXES-1:0][COORD_W-1:0]     quo;
    logic [NUM_AXES-1:0][2:0]             bnd;
  } div_t;

endpackage

// File: src/shca_div_stage.sv
module shca_div_stage #(
  parameter int FIRST_BIT = 23
) (
  input  shca_pkg::div_t                 d_i,
  input  logic [shca_pkg::POS_W-1:0]     cs,
  output shca_pkg::div_t                 d_o
);

  always_comb begin
    logic [shca_pkg::POS_W:0]       t;
    logic [shca_pkg::POS_W-1:0]     rem;
    logic [shca_pkg::COORD_W-1:0]   quo;
    d_o = d_i;
    for (int a = 0; a < shca_pkg::NUM_AXES; a++) begin
      rem = d_i.rem[a];
      quo = d_i.quo[a];
      for (int b = 0; b < shca_pkg::DIV_BITS; b++) begin
        t = {rem, d_i.pos[a][FIRST_BIT-b]};
        if (t >= {1'b0, cs}) begin
          rem = shca_pkg::POS_W'(t - {1'b0, cs});
          quo = {quo[shca_pkg::COORD_W-2:0], 1'b1};
        end else begin
          rem = t[shca_pkg::POS_W-1:0];
          quo = {quo[shca_pkg::COORD_W-2:0], 1'b0};
        end
      end
      d_o.rem[a] = rem;
      d_o.quo[a] = quo;
    end
  end

endmodule

// File: src/spatial_hash_cell_assign_core.sv
// Channel  | Handshake               | Payload
// input    | start / busy            | in_object_index, in_pos_x/y/z, in_radius
// result   | out_strobe (no stall)   | out_cell_word, out_object_word, out_cells_used,
//          |                         | out_last_entry
// config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// An object gives 8 result items on consecutive cycles; sustained throughput is set
// by the single-entry result port. The first item passes from the input register
// (loaded at the accepting edge) through 8 divider stages (3 quotient bits each), the
// side test, mask count, serialiser load and output register to the result ports.
// Reset is synchronous and clears valid state, the config registers and the serialiser
// control and out_strobe. busy rises once the pipeline backs up behind the serialiser.
module spatial_hash_cell_assign_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [shca_pkg::IDX_W-1:0]   in_object_index,
  input  logic [shca_pkg::POS_W-1:0]   in_pos_x,
  input  logic [shca_pkg::POS_W-1:0]   in_pos_y,
  input  logic [shca_pkg::POS_W-1:0]   in_pos_z,
  input  logic [shca_pkg::POS_W-1:0]   in_radius,
  output logic                         out_strobe,
  output logic [31:0]                  out_cell_word,
  output logic [13:0]                  out_object_word,
  output logic [3:0]                   out_cells_used,
  output logic                         out_last_entry,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [31:0]                  cfg_data
);

  localparam int NA = shca_pkg::NUM_AXES;
  localparam int CW = shca_pkg::COORD_W;

  logic [shca_pkg::POS_W-1:0] cell_size_r;
  logic [shca_pkg::BND_W-1:0] low_bound_r, high_bound_r;
  logic [shca_pkg::POS_W-1:0] cs;

  assign cfg_ready = 1'b1;
  assign cs = (cell_size_r == '0) ? shca_pkg::POS_W'(1) : cell_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r  <= shca_pkg::CELL_SIZE_RST;
      low_bound_r  <= shca_pkg::LOW_BOUND_RST;
      high_bound_r <= shca_pkg::HIGH_BOUND_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        shca_pkg::REG_CELL_SIZE:  cell_size_r  <= cfg_data[shca_pkg::POS_W-1:0];
        shca_pkg::REG_LOW_BOUND:  low_bound_r  <= cfg_data[shca_pkg::BND_W-1:0];
        shca_pkg::REG_HIGH_BOUND: high_bound_r <= cfg_data[shca_pkg::BND_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic adv, accept, ser_take;
  logic fin_v_r, ser_act_r;
  logic [2:0] ser_cnt_r;

  assign ser_take = !ser_act_r || (ser_cnt_r == 3'(shca_pkg::ENTRIES - 1));
  assign adv      = !fin_v_r || ser_take;

  shca_pkg::div_t st_r [shca_pkg::DIV_STAGES+1];
  shca_pkg::div_t st_c [shca_pkg::DIV_STAGES+1];
  shca_pkg::div_t in_c;

  assign busy   = st_r[0].v && !adv;
  assign accept = start && !busy;

  // Bound test for each axis and offset, on the incoming item
  always_comb begin
    logic signed [shca_pkg::POS_W+1:0] sh, lo, hi;
    in_c     = '0;
    in_c.v   = accept;
    in_c.idx = in_object_index;
    in_c.pos = {in_pos_z, in_pos_y, in_pos_x};
    in_c.rad = in_radius;
    lo = 26'(signed'(low_bound_r));
    hi = 26'(signed'(high_bound_r));
    for (int a = 0; a < NA; a++) begin
      for (int d = 0; d < 3; d++) begin
        sh = signed'({2'b00, in_c.pos[a]});
        if (d == 0) sh = sh - signed'({2'b00, cs});
        else if (d == 2) sh = sh + signed'({2'b00, cs});
        in_c.bnd[a][d] = (sh > lo) && (sh < hi);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r[0].v <= 1'b0;
    end else if (adv || !st_r[0].v) begin
      st_r[0] <= in_c;
    end
  end

  assign st_c[0] = st_r[0];

  for (genvar k = 1; k <= shca_pkg::DIV_STAGES; k++) begin : g_div
    shca_div_stage #(
      .FIRST_BIT(shca_pkg::POS_W - 1 - (k - 1) * shca_pkg::DIV_BITS)
    ) u_stage (
      .d_i(st_r[k-1]),
      .cs (cs),
      .d_o(st_c[k])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[k].v <= 1'b0;
      end else if (adv) begin
        st_r[k] <= st_c[k];
      end
    end
  end

  // Side test: allow bit d when offset d-1 is usable on that axis
  shca_pkg::div_t dq;
  logic                      post_v_r;
  logic [shca_pkg::IDX_W-1:0] post_idx_r;
  logic [NA-1:0][CW-1:0]     post_cq_r;
  logic [NA-1:0][2:0]        post_alw_r;
  logic [NA-1:0][2:0]        alw_c;

  assign dq = st_r[shca_pkg::DIV_STAGES];

  always_comb begin
    logic lo_side, hi_side;
    for (int a = 0; a < NA; a++) begin
      lo_side = dq.rem[a] < dq.rad;
      hi_side = !lo_side && ((cs - dq.rem[a]) < dq.rad);
      alw_c[a][0] = lo_side && dq.bnd[a][0];
      alw_c[a][1] = dq.bnd[a][1];
      alw_c[a][2] = hi_side && dq.bnd[a][2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      post_v_r <= 1'b0;
    end else if (adv) begin
      post_v_r <= dq.v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      post_idx_r <= dq.idx;
      post_cq_r  <= dq.quo;
      post_alw_r <= alw_c;
    end
  end

  // Neighbour mask and entry count
  logic [shca_pkg::NUM_OFFS-1:0] mask_c, fin_mask_r;
  logic [3:0]                    used_c, fin_used_r;
  logic [shca_pkg::IDX_W-1:0]    fin_idx_r;
  logic [NA-1:0][CW-1:0]         fin_cq_r;

  always_comb begin
    logic [4:0] pc;
    for (int z = 0; z < 3; z++)
      for (int y = 0; y < 3; y++)
        for (int x = 0; x < 3; x++)
          mask_c[z*9 + y*3 + x] = post_alw_r[0][x] && post_alw_r[1][y] && post_alw_r[2][z];
    mask_c[shca_pkg::HOME_OFF] = 1'b0;
    pc = 5'($countones(mask_c));
    used_c = (pc >= 5'(shca_pkg::ENTRIES - 1)) ? 4'(shca_pkg::ENTRIES) : 4'(pc + 5'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (adv) begin
      fin_v_r <= post_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_idx_r  <= post_idx_r;
      fin_cq_r   <= post_cq_r;
      fin_mask_r <= mask_c;
      fin_used_r <= used_c;
    end
  end

  // Result serialiser: home first, then lowest remaining neighbour, then filler
  logic [shca_pkg::IDX_W-1:0]    ser_idx_r;
  logic [NA-1:0][CW-1:0]         ser_cq_r;
  logic [shca_pkg::NUM_OFFS-1:0] ser_mask_r, mask_nxt;
  logic [3:0]                    ser_used_r;
  logic [31:0]                   cw_c;
  logic [13:0]                   ow_c;
  logic                          load;

  assign load = ser_take && fin_v_r;

  always_comb begin
    logic [shca_pkg::NUM_OFFS-1:0] pick;
    logic [3*CW-1:0]               key;
    pick = '0;
    key  = '0;
    for (int z = 2; z >= 0; z--)
      for (int y = 2; y >= 0; y--)
        for (int x = 2; x >= 0; x--)
          if (ser_mask_r[z*9 + y*3 + x]) begin
            pick = '0;
            pick[z*9 + y*3 + x] = 1'b1;
            key = {CW'(ser_cq_r[0] + CW'(x) - CW'(1)),
                   CW'(ser_cq_r[1] + CW'(y) - CW'(1)),
                   CW'(ser_cq_r[2] + CW'(z) - CW'(1))};
          end
    mask_nxt = ser_mask_r;
    if (ser_cnt_r == 3'd0) begin
      cw_c = {7'd0, ser_cq_r[0], ser_cq_r[1], ser_cq_r[2], 1'b0};
      ow_c = {1'b0, ser_idx_r, 1'b1};
    end else if (ser_mask_r != '0) begin
      cw_c = {7'd0, key, 1'b1};
      ow_c = {1'b0, ser_idx_r, 1'b0};
      mask_nxt = ser_mask_r & ~pick;
    end else begin
      cw_c = '1;
      ow_c = {ser_idx_r, 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_act_r  <= 1'b0;
      ser_cnt_r  <= '0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= ser_act_r;
      if (load) begin
        ser_act_r <= 1'b1;
        ser_cnt_r <= '0;
      end else if (ser_act_r) begin
        ser_act_r <= (ser_cnt_r != 3'(shca_pkg::ENTRIES - 1));
        ser_cnt_r <= ser_cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ser_idx_r  <= fin_idx_r;
      ser_cq_r   <= fin_cq_r;
      ser_mask_r <= fin_mask_r;
      ser_used_r <= fin_used_r;
    end else if (ser_act_r) begin
      ser_mask_r <= mask_nxt;
    end
    out_cell_word   <= cw_c;
    out_object_word <= ow_c;
    out_cells_used  <= ser_used_r;
    out_last_entry  <= ser_act_r && (ser_cnt_r == 3'(shca_pkg::ENTRIES - 1));
  end

`ifndef SYNTHESIS
  a_run_contig: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_entry |=> out_strobe)
    else $error("result run broken before its last item");

  a_used_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_entry |=> $stable(out_cells_used))
    else $error("cells_used changed inside a run");

  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_cells_used >= 4'd1) && (out_cells_used <= 4'd8))
    else $error("cells_used out of range");

  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> fin_v_r && ser_act_r)
    else $error("busy without a backed-up serialiser");
`endif

endmodule
